FILE: rtl/pwmt_pkg.sv
// Shared types, constants and register indexes of the four-comparator PWM timer.
package pwmt_pkg;

    // Channel count the datapath is built for, and the default build
    localparam int CH_MAX              = 4;
    localparam int DEF_NUM_COMPARATORS = 4;
    localparam int DEF_COMPARE_WIDTH   = 16;

    // Fixed field widths
    localparam int COUNT_W     = 31;
    localparam int SCALED_W    = 16;
    localparam int SCALE_W     = 4;
    localparam int MODES_W     = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE         = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_ALWAYS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_COMPARE  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODES         = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_0     = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_1     = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_2     = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_3     = 8'd7;

    // Input actions
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ARM   = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_CLEAR = 2'd3
    } pwmt_action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COUNT_W-1:0] value;
    } pwmt_in_t;

    typedef struct packed {
        logic [CH_MAX-1:0]   gpio_bits;
        logic [CH_MAX-1:0]   pending_bits;
        logic [SCALED_W-1:0] scaled_count;
        logic [COUNT_W-1:0]  count_value;
        logic                one_shot_armed;
    } pwmt_out_t;

    // Configuration seen by the comparator bank
    typedef struct packed {
        logic [SCALE_W-1:0]              scale;
        logic                            enable_always;
        logic                            zero_compare;
        logic [MODES_W-1:0]              modes;
        logic [CH_MAX-1:0][SCALED_W-1:0] thresholds;
    } pwmt_cfg_t;

endpackage

FILE: rtl/pwmt_compare.sv
// Comparator bank: center fold, threshold compare and gang gating per channel.
module pwmt_compare
    import pwmt_pkg::*;
#(
    parameter int NUM_COMPARATORS = DEF_NUM_COMPARATORS,
    parameter int COMPARE_WIDTH   = DEF_COMPARE_WIDTH
)
(
    input  pwmt_cfg_t           cfg,
    input  logic [SCALED_W-1:0] scaled,
    output logic [CH_MAX-1:0]   match,
    output logic [CH_MAX-1:0]   gpio
);

    localparam logic [SCALED_W-1:0] SCALED_MASK =
        SCALED_W'((32'd1 << COMPARE_WIDTH) - 32'd1);

    // Build each channel; channels past the configured count stay quiet
    for (genvar i = 0; i < CH_MAX; i++) begin : g_ch
        if (i < NUM_COMPARATORS) begin : g_used
            localparam int NXT = (i + 1) % NUM_COMPARATORS;
            logic [SCALED_W-1:0] folded;

            // Fold the upper half back down in center mode
            assign folded = (cfg.modes[i] && scaled[COMPARE_WIDTH-1]) ?
                            (scaled ^ SCALED_MASK) : scaled;
            assign match[i] = (folded >= (cfg.thresholds[i] & SCALED_MASK));
            // Gang: drop the output while the next channel matches
            assign gpio[i] = match[i] & ~(cfg.modes[CH_MAX+i] & match[NXT]);
        end else begin : g_unused
            assign match[i] = 1'b0;
            assign gpio[i]  = 1'b0;
        end
    end

endmodule

FILE: rtl/pwm_timer_four_compare.sv
// Top level of the PWM timer with four comparators.
// A beat accepted into the input register moves on to the result register once the
// result slot is free or draining, and is offered at the output from there.
// Throughput is one beat per cycle while the output is not stalled, set by the combinational
// path from the input register through counter, shifter and comparators. Reset (rst_n low,
// asynchronous) clears the counter, restart, one-shot, match history, pending bits, gpio
// hold, all configuration registers and the valid flags of both pipeline stages.
module pwm_timer_four_compare
    import pwmt_pkg::*;
#(
    parameter int NUM_COMPARATORS = DEF_NUM_COMPARATORS,
    parameter int COMPARE_WIDTH   = DEF_COMPARE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pwmt_in_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pwmt_out_t              out_data
);

    localparam logic [SCALED_W-1:0] SCALED_MASK =
        SCALED_W'((32'd1 << COMPARE_WIDTH) - 32'd1);
    localparam logic [CH_MAX-1:0] CH_MASK =
        CH_MAX'((32'd1 << NUM_COMPARATORS) - 32'd1);

    pwmt_cfg_t           cfg_reg;
    pwmt_in_t            in_reg;
    logic                in_valid_reg;
    pwmt_out_t           out_reg;
    logic                out_valid_reg;

    logic [COUNT_W-1:0]  counter_reg, counter_next;
    logic                restart_reg, restart_next;
    logic                one_shot_reg, one_shot_next;
    logic [CH_MAX-1:0]   prev_match_reg, prev_match_next;
    logic [CH_MAX-1:0]   pending_reg, pending_next;
    logic [CH_MAX-1:0]   gpio_reg, gpio_next;

    logic                advance;
    logic                running;
    logic                do_tick;
    pwmt_action_t        action;
    logic [COUNT_W-1:0]  shifted;
    logic [SCALED_W-1:0] scaled;
    logic                wrap;
    logic [CH_MAX-1:0]   match;
    logic [CH_MAX-1:0]   gpio;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE:         cfg_reg.scale         <= cfg_data[SCALE_W-1:0];
                REG_ENABLE_ALWAYS: cfg_reg.enable_always <= cfg_data[0];
                REG_ZERO_COMPARE:  cfg_reg.zero_compare  <= cfg_data[0];
                REG_MODES:         cfg_reg.modes         <= cfg_data[MODES_W-1:0];
                REG_COMPARE_0:     cfg_reg.thresholds[0] <= cfg_data[SCALED_W-1:0];
                REG_COMPARE_1:     cfg_reg.thresholds[1] <= cfg_data[SCALED_W-1:0];
                REG_COMPARE_2:     cfg_reg.thresholds[2] <= cfg_data[SCALED_W-1:0];
                REG_COMPARE_3:     cfg_reg.thresholds[3] <= cfg_data[SCALED_W-1:0];
                default:           ;
            endcase
        end
    end

    // Handshake: move the input beat on when the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    assign action  = pwmt_action_t'(in_reg.action);
    assign running = cfg_reg.enable_always | one_shot_reg;
    assign do_tick = (action == ACT_TICK) && running;

    // Scale the new counter value; comparators and result both use it
    assign shifted = counter_next >> cfg_reg.scale;
    assign scaled  = shifted[SCALED_W-1:0] & SCALED_MASK;
    assign wrap    = (scaled == SCALED_MASK);

    pwmt_compare #(
        .NUM_COMPARATORS (NUM_COMPARATORS),
        .COMPARE_WIDTH   (COMPARE_WIDTH)
    ) u_compare (
        .cfg    (cfg_reg),
        .scaled (scaled),
        .match  (match),
        .gpio   (gpio)
    );

    // Counter update
    always_comb
    begin
        counter_next = counter_reg;
        if (action == ACT_LOAD)
        begin
            counter_next = in_reg.value;
        end
        else if (do_tick)
        begin
            counter_next = restart_reg ? '0 : counter_reg + COUNT_W'(1);
        end
    end

    // Remaining state update for the current beat
    always_comb
    begin
        restart_next    = restart_reg;
        one_shot_next   = one_shot_reg;
        prev_match_next = prev_match_reg;
        pending_next    = pending_reg;
        gpio_next       = gpio_reg;
        unique case (action)
            ACT_TICK:
            begin
                if (running)
                begin
                    restart_next    = wrap | (match[0] & cfg_reg.zero_compare);
                    one_shot_next   = one_shot_reg & ~wrap & ~match[0];
                    gpio_next       = gpio;
                    pending_next    = pending_reg | (match & ~prev_match_reg);
                    prev_match_next = match;
                end
            end
            ACT_ARM:   one_shot_next = 1'b1;
            ACT_LOAD:  ;
            ACT_CLEAR: pending_next = pending_reg & ~in_reg.value[CH_MAX-1:0];
            default:   ;
        endcase
    end

    // Timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg    <= '0;
            restart_reg    <= 1'b0;
            one_shot_reg   <= 1'b0;
            prev_match_reg <= '0;
            pending_reg    <= '0;
            gpio_reg       <= '0;
        end
        else if (advance)
        begin
            counter_reg    <= counter_next;
            restart_reg    <= restart_next;
            one_shot_reg   <= one_shot_next;
            prev_match_reg <= prev_match_next;
            pending_reg    <= pending_next;
            gpio_reg       <= gpio_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.gpio_bits      <= gpio_next;
            out_reg.pending_bits   <= pending_next;
            out_reg.scaled_count   <= scaled;
            out_reg.count_value    <= counter_next;
            out_reg.one_shot_armed <= one_shot_next;
        end
    end

    // Unused channels never raise pending
    a_pending_used: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~CH_MASK) == '0)
        else $error("pending bit set on unused channel");

    // Restart is only requested by a running tick
    a_restart_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(restart_reg) |-> $past(advance && do_tick))
        else $error("restart raised without a tick");

    // One-shot is only armed by an arm beat
    a_arm_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(one_shot_reg) |-> $past(advance && action == ACT_ARM))
        else $error("one-shot armed without an arm beat");

    // Counter holds while no beat advances
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(counter_reg))
        else $error("counter moved without a beat");

endmodule
